// ===== sv/idbrc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// idbrc_pkg
// Shared types and constants of the id block reservation cache: request and
// response beats, table entry layout, opcodes and register indexes.
// ----------------------------------------------------------------------------
package idbrc_pkg;

	localparam int unsigned ID_W        = 64;
	localparam int unsigned COUNT_W     = 32;
	localparam int unsigned STEP_W      = 13;
	localparam int unsigned CFG_INDEX_W = 1;

	localparam logic [STEP_W-1:0] STEP_RESET = 13'd64;
	localparam logic [STEP_W-1:0] CAP_RESET  = 13'd4096;

	// request opcodes
	localparam logic [1:0] OP_RESERVE      = 2'd0;
	localparam logic [1:0] OP_FORGET_SPACE = 2'd1;
	localparam logic [1:0] OP_FORGET_ALL   = 2'd2;

	// response status codes
	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_STEP = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_STEP_CAP     = 1'd1;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [1:0]         space_index;
		logic [3:0]         seq_name_index;
		logic [COUNT_W-1:0] request_count;
	} req_t;

	typedef struct packed {
		logic            status;
		logic [ID_W-1:0] first_id;
		logic            refilled;
	} rsp_t;

	// one cached block of a sequence
	typedef struct packed {
		logic              valid;
		logic [ID_W-1:0]   next_id;
		logic [ID_W-1:0]   end_id;
		logic [STEP_W-1:0] step;
	} cache_entry_t;

	// outcome of one reserve on one entry
	typedef struct packed {
		cache_entry_t    entry;
		logic [ID_W-1:0] ctr;
		logic [ID_W-1:0] first;
		logic            refilled;
	} calc_res_t;

endpackage
`default_nettype wire

// ===== sv/id_block_reservation_cache.sv =====
`default_nettype none
// Reserve: the table read is registered at the accepting edge, and the result is computed,
//   written back and registered in the following state, which waits while rsp_stall holds.
// Zero count, bad index or unused opcode: answered from the response state, no table access.
// Forget space sweeps one space, forget all sweeps every entry; one table entry cleared per cycle.
// req_stall stays high until the result of each request is registered, so a new one waits.
// After reset a clearing pass over all SPACES * NAMES_PER_SPACE entries runs with req_stall high.
// ----------------------------------------------------------------------------
// id_block_reservation_cache
// Hands out runs of consecutive ids from per-sequence cached blocks over a
// backing counter per sequence, with refill, step doubling and forgetting.
// ----------------------------------------------------------------------------
module id_block_reservation_cache #(
	parameter int unsigned SPACES          = 4,
	parameter int unsigned NAMES_PER_SPACE = 16
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    req_valid,
	output logic                                   req_stall,
	input  idbrc_pkg::req_t                        req,
	output logic                                   rsp_valid,
	input  wire                                    rsp_stall,
	output idbrc_pkg::rsp_t                        rsp,
	input  wire                                    cfg_valid,
	output logic                                   cfg_ready,
	input  wire  [idbrc_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire  [idbrc_pkg::STEP_W-1:0]           cfg_data
);

	localparam int unsigned ENTRIES = SPACES * NAMES_PER_SPACE;
	localparam int unsigned ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(ENTRIES - 1);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_EXEC  = 5'b00100,
		ST_SWEEP = 5'b01000,
		ST_RESP  = 5'b10000
	} state_t;

	state_t                          state_q, state_d;
	logic [ADDR_W-1:0]               sweep_q, sweep_d;
	logic [ADDR_W-1:0]               last_q, last_d;
	logic                            rsp_valid_q;
	idbrc_pkg::rsp_t                 rsp_q, rsp_d;
	idbrc_pkg::rsp_t                 res_q, res_d;
	logic                            load_res, load_rsp;
	logic [idbrc_pkg::STEP_W-1:0]    init_step_q, step_cap_q;

	logic [ADDR_W-1:0]               addr_s1;
	logic [idbrc_pkg::COUNT_W-1:0]   count_s1;

	logic                            req_accept, out_free;
	logic                            sp_ok, nm_ok;
	logic [ADDR_W-1:0]               entry_addr, space_base, space_last;

	logic                            rd_en;
	idbrc_pkg::cache_entry_t         rd_cache_s1;
	logic [idbrc_pkg::ID_W-1:0]      rd_ctr_s1;
	logic                            cache_we, ctr_we;
	logic [ADDR_W-1:0]               cache_waddr, ctr_waddr;
	idbrc_pkg::cache_entry_t         cache_wdata;
	logic [idbrc_pkg::ID_W-1:0]      ctr_wdata;
	idbrc_pkg::calc_res_t            calc;

	// handshakes
	assign req_stall  = (state_q != ST_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;
	assign cfg_ready  = 1'b1;

	// request decode
	assign sp_ok      = (32'(req.space_index) < SPACES);
	assign nm_ok      = (32'(req.seq_name_index) < NAMES_PER_SPACE);
	assign entry_addr = ADDR_W'(32'(req.space_index) * NAMES_PER_SPACE
		+ 32'(req.seq_name_index));
	assign space_base = ADDR_W'(32'(req.space_index) * NAMES_PER_SPACE);
	assign space_last = ADDR_W'(32'(req.space_index) * NAMES_PER_SPACE
		+ NAMES_PER_SPACE - 1);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_step_q <= idbrc_pkg::STEP_RESET;
			step_cap_q  <= idbrc_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				idbrc_pkg::CFG_INITIAL_STEP: init_step_q <= cfg_data;
				idbrc_pkg::CFG_STEP_CAP:     step_cap_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequence table
	idbrc_table #(
		.ENTRIES (ENTRIES)
	) u_table (
		.clk         (clk),
		.rd_en       (rd_en),
		.rd_addr     (entry_addr),
		.rd_cache_s1 (rd_cache_s1),
		.rd_ctr_s1   (rd_ctr_s1),
		.cache_we    (cache_we),
		.cache_waddr (cache_waddr),
		.cache_wdata (cache_wdata),
		.ctr_we      (ctr_we),
		.ctr_waddr   (ctr_waddr),
		.ctr_wdata   (ctr_wdata)
	);

	// reserve datapath on the read data
	idbrc_calc u_calc (
		.entry        (rd_cache_s1),
		.ctr          (rd_ctr_s1),
		.count        (count_s1),
		.initial_step (init_step_q),
		.step_cap     (step_cap_q),
		.res          (calc)
	);

	// sequencer
	always_comb begin
		state_d     = state_q;
		sweep_d     = sweep_q;
		last_d      = last_q;
		rd_en       = 1'b0;
		cache_we    = 1'b0;
		ctr_we      = 1'b0;
		cache_waddr = sweep_q;
		ctr_waddr   = sweep_q;
		cache_wdata = '0;
		ctr_wdata   = '0;
		load_res    = 1'b0;
		res_d       = '0;
		load_rsp    = 1'b0;
		rsp_d       = res_q;
		unique case (state_q)
			ST_CLEAR: begin
				cache_we = 1'b1;
				ctr_we   = 1'b1;
				sweep_d  = sweep_q + 1'b1;
				if (sweep_q == last_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_accept) begin
					unique case (req.opcode)
						idbrc_pkg::OP_RESERVE: begin
							if (req.request_count != '0 && sp_ok && nm_ok) begin
								rd_en   = 1'b1;
								state_d = ST_EXEC;
							end else begin
								load_res     = 1'b1;
								res_d.status = idbrc_pkg::STATUS_REJECT;
								state_d      = ST_RESP;
							end
						end
						idbrc_pkg::OP_FORGET_SPACE: begin
							if (sp_ok) begin
								sweep_d = space_base;
								last_d  = space_last;
								state_d = ST_SWEEP;
							end else begin
								load_res = 1'b1;
								state_d  = ST_RESP;
							end
						end
						idbrc_pkg::OP_FORGET_ALL: begin
							sweep_d = '0;
							last_d  = LAST_ENTRY;
							state_d = ST_SWEEP;
						end
						default: begin
							load_res = 1'b1;
							state_d  = ST_RESP;
						end
					endcase
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					cache_we       = 1'b1;
					cache_waddr    = addr_s1;
					cache_wdata    = calc.entry;
					ctr_we         = calc.refilled;
					ctr_waddr      = addr_s1;
					ctr_wdata      = calc.ctr;
					load_rsp       = 1'b1;
					rsp_d.status   = idbrc_pkg::STATUS_OK;
					rsp_d.first_id = calc.first;
					rsp_d.refilled = calc.refilled;
					state_d        = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				cache_we = 1'b1;
				sweep_d  = sweep_q + 1'b1;
				if (sweep_q == last_q) begin
					load_res = 1'b1;
					state_d  = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sweep_q     <= '0;
			last_q      <= LAST_ENTRY;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sweep_q <= sweep_d;
			last_q  <= last_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_s1  <= entry_addr;
			count_s1 <= req.request_count;
		end
		if (load_res) begin
			res_q <= res_d;
		end
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

endmodule
`default_nettype wire

// ===== sv/idbrc_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// idbrc_table
// Sequence table storage: a cache memory holding the cached block of every
// entry and a counter memory holding the backing counters. One shared read
// port with registered data, one write port per memory.
// ----------------------------------------------------------------------------
module idbrc_table #(
	parameter int unsigned ENTRIES = 64,
	localparam int unsigned ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire                                   clk,
	input  wire                                   rd_en,
	input  wire  [ADDR_W-1:0]                     rd_addr,
	output idbrc_pkg::cache_entry_t               rd_cache_s1,
	output logic [idbrc_pkg::ID_W-1:0]            rd_ctr_s1,
	input  wire                                   cache_we,
	input  wire  [ADDR_W-1:0]                     cache_waddr,
	input  idbrc_pkg::cache_entry_t               cache_wdata,
	input  wire                                   ctr_we,
	input  wire  [ADDR_W-1:0]                     ctr_waddr,
	input  wire  [idbrc_pkg::ID_W-1:0]            ctr_wdata
);

	idbrc_pkg::cache_entry_t          cache_mem [ENTRIES];
	logic [idbrc_pkg::ID_W-1:0]       ctr_mem   [ENTRIES];

	// cache memory write
	always_ff @(posedge clk) begin
		if (cache_we) begin
			cache_mem[cache_waddr] <= cache_wdata;
		end
	end

	// counter memory write
	always_ff @(posedge clk) begin
		if (ctr_we) begin
			ctr_mem[ctr_waddr] <= ctr_wdata;
		end
	end

	// registered read of both memories, held between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_cache_s1 <= cache_mem[rd_addr];
			rd_ctr_s1   <= ctr_mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/idbrc_calc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// idbrc_calc
// Reserve datapath: serves a count from the cached block when enough ids
// remain, otherwise refills from the backing counter and doubles the step.
// ----------------------------------------------------------------------------
module idbrc_calc (
	input  idbrc_pkg::cache_entry_t                entry,
	input  wire  [idbrc_pkg::ID_W-1:0]             ctr,
	input  wire  [idbrc_pkg::COUNT_W-1:0]          count,
	input  wire  [idbrc_pkg::STEP_W-1:0]           initial_step,
	input  wire  [idbrc_pkg::STEP_W-1:0]           step_cap,
	output idbrc_pkg::calc_res_t                   res
);

	logic [idbrc_pkg::ID_W-1:0]    nx;
	logic [idbrc_pkg::ID_W-1:0]    en;
	logic [idbrc_pkg::STEP_W-1:0]  st;
	logic [idbrc_pkg::ID_W-1:0]    avail;
	logic [idbrc_pkg::ID_W-1:0]    cnt64;
	logic                          hit;
	logic [idbrc_pkg::COUNT_W-1:0] take;
	logic [idbrc_pkg::ID_W-1:0]    at;
	logic [idbrc_pkg::ID_W-1:0]    refill_end;
	logic [idbrc_pkg::STEP_W:0]    dbl;
	logic [idbrc_pkg::STEP_W-1:0]  st_next;

	// a cleared entry reads as an empty block with the initial step
	assign nx = entry.valid ? entry.next_id : '0;
	assign en = entry.valid ? entry.end_id  : '0;
	assign st = entry.valid ? entry.step    : initial_step;

	// enough ids left in the cached block
	assign cnt64 = {{(idbrc_pkg::ID_W - idbrc_pkg::COUNT_W){1'b0}}, count};
	assign avail = en - nx;
	assign hit   = (avail >= cnt64);

	// refill block: max(count, step) ids from the counter, zero counter means one
	assign take       = (count > idbrc_pkg::COUNT_W'(st)) ? count : idbrc_pkg::COUNT_W'(st);
	assign at         = (ctr == '0) ? idbrc_pkg::ID_W'(1) : ctr;
	assign refill_end = at + {{(idbrc_pkg::ID_W - idbrc_pkg::COUNT_W){1'b0}}, take};

	// step doubling limited by the cap
	assign dbl     = {st, 1'b0};
	assign st_next = (dbl > {1'b0, step_cap}) ? step_cap : dbl[idbrc_pkg::STEP_W-1:0];

	always_comb begin
		res.entry.valid = 1'b1;
		if (hit) begin
			res.entry.next_id = nx + cnt64;
			res.entry.end_id  = en;
			res.entry.step    = st;
			res.ctr           = ctr;
			res.first         = nx;
			res.refilled      = 1'b0;
		end else begin
			res.entry.next_id = at + cnt64;
			res.entry.end_id  = refill_end;
			res.entry.step    = st_next;
			res.ctr           = refill_end;
			res.first         = at;
			res.refilled      = 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== sv/idbrc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// idbrc_checker
// Port-level checks of the id block reservation cache: response beats follow
// request beats one for one, and response fields agree with each other.
// ----------------------------------------------------------------------------
module idbrc_checker (
	input wire             clk,
	input wire             arst_n,
	input wire             req_valid,
	input wire             req_stall,
	input wire             rsp_valid,
	input wire             rsp_stall,
	input idbrc_pkg::rsp_t rsp
);

	logic       req_beat, rsp_beat;
	logic [1:0] pend_q;

	assign req_beat = req_valid && !req_stall;
	assign rsp_beat = rsp_valid && !rsp_stall;

	// requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_beat) - 2'(rsp_beat);
		end
	end

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// no response beat without an open request
	a_no_extra_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_beat |-> pend_q != 2'd0)
		else $error("response beat without a request");

	// at most one finished result waits while a new request is taken
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat |-> pend_q <= 2'd1)
		else $error("request taken with two results outstanding");

	// a rejection carries no id and no refill
	a_reject_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == idbrc_pkg::STATUS_REJECT |->
			rsp.first_id == '0 && !rsp.refilled)
		else $error("rejected response carries an id");

	// a refill grants from a nonzero counter position
	a_refill_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.refilled |->
			rsp.status == idbrc_pkg::STATUS_OK && rsp.first_id != '0)
		else $error("refill response with zero id or error status");

endmodule

bind id_block_reservation_cache idbrc_checker u_idbrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the id block reservation cache. Reserve, forget and
// unused requests stream through the request channel under random idling on
// both sides. A behavioral copy of the sequence table predicts every response
// beat, and each beat is checked in order. The run steps through several
// step and cap register settings, including zero and all-ones values.
// ----------------------------------------------------------------------------
module tb;

	localparam int          PHASES           = 8;
	localparam int          RANDOM_PER_PHASE = 135;
	localparam int          SETTLE_CYCLES    = 80;
	localparam int          CYCLE_LIMIT      = 500000;
	localparam int          ENTRY_COUNT      = 64;
	localparam int          NAME_COUNT       = 16;
	localparam logic [1:0]  OP_UNUSED        = 2'd3;

	// clock, reset and block ports
	logic                              clk        = 1'b0;
	logic                              arst_n     = 1'b0;
	logic                              req_valid  = 1'b0;
	logic                              req_stall;
	idbrc_pkg::req_t                   req        = '0;
	logic                              rsp_valid;
	logic                              rsp_stall  = 1'b0;
	idbrc_pkg::rsp_t                   rsp;
	logic                              cfg_valid  = 1'b0;
	logic                              cfg_ready;
	logic [idbrc_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
	logic [idbrc_pkg::STEP_W-1:0]      cfg_data   = '0;

	// register settings walked through, one per phase
	logic [idbrc_pkg::STEP_W-1:0] step_plan [PHASES] = '{13'd64, 13'd1, 13'd4096, 13'd0,
		13'd8191, 13'd1, 13'd300, 13'd8191};
	logic [idbrc_pkg::STEP_W-1:0] cap_plan [PHASES] = '{13'd4096, 13'd4096, 13'd4096,
		13'd8191, 13'd8191, 13'd1, 13'd17, 13'd2};

	// shadow of the sequence table and registers
	logic                         blk_live [ENTRY_COUNT];
	logic [idbrc_pkg::ID_W-1:0]   blk_next [ENTRY_COUNT];
	logic [idbrc_pkg::ID_W-1:0]   blk_end  [ENTRY_COUNT];
	logic [idbrc_pkg::STEP_W-1:0] blk_step [ENTRY_COUNT];
	logic [idbrc_pkg::ID_W-1:0]   id_ctr   [ENTRY_COUNT];
	logic [idbrc_pkg::STEP_W-1:0] cur_initial_step = idbrc_pkg::STEP_RESET;
	logic [idbrc_pkg::STEP_W-1:0] cur_step_cap     = idbrc_pkg::CAP_RESET;

	idbrc_pkg::req_t reqs_waiting [$];
	idbrc_pkg::rsp_t grants_due   [$];

	int send_idle_pct  = 0;
	int sink_stall_pct = 0;
	int mismatch_count = 0;
	int beats_checked  = 0;
	int refills_seen   = 0;
	int rejects_seen   = 0;
	int forgets_seen   = 0;
	int cycle_count    = 0;

	id_block_reservation_cache #(
		.SPACES          (4),
		.NAMES_PER_SPACE (NAME_COUNT)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	initial begin
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			blk_live[i] = 1'b0;
			blk_next[i] = '0;
			blk_end[i]  = '0;
			blk_step[i] = '0;
			id_ctr[i]   = '0;
		end
	end

	function automatic void note_error(string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("ERROR: %s", msg);
	endfunction

	// update the shadow table with one request and return the response it earns
	function automatic idbrc_pkg::rsp_t apply_request(idbrc_pkg::req_t r);
		idbrc_pkg::rsp_t            o;
		logic [5:0]                 e;
		logic [idbrc_pkg::ID_W-1:0] nx, en, cnt, take, at;
		logic [idbrc_pkg::STEP_W:0] st, dbl;
		o        = '0;
		o.status = idbrc_pkg::STATUS_OK;
		e        = {r.space_index, r.seq_name_index};
		case (r.opcode)
			idbrc_pkg::OP_RESERVE: begin
				if (r.request_count == '0) begin
					o.status = idbrc_pkg::STATUS_REJECT;
				end else begin
					nx  = blk_live[e] ? blk_next[e] : '0;
					en  = blk_live[e] ? blk_end[e] : '0;
					st  = blk_live[e] ? {1'b0, blk_step[e]} : {1'b0, cur_initial_step};
					cnt = idbrc_pkg::ID_W'(r.request_count);
					if (en - nx >= cnt) begin
						// served from the cached block
						o.first_id  = nx;
						blk_next[e] = nx + cnt;
						blk_end[e]  = en;
						blk_step[e] = st[idbrc_pkg::STEP_W-1:0];
					end else begin
						// refill from the backing counter, zero counter means one
						take        = (cnt > idbrc_pkg::ID_W'(st)) ? cnt
							: idbrc_pkg::ID_W'(st);
						at          = (id_ctr[e] == '0) ? idbrc_pkg::ID_W'(1) : id_ctr[e];
						id_ctr[e]   = at + take;
						blk_next[e] = at + cnt;
						blk_end[e]  = at + take;
						dbl         = st << 1;
						blk_step[e] = (dbl > {1'b0, cur_step_cap}) ? cur_step_cap
							: dbl[idbrc_pkg::STEP_W-1:0];
						o.first_id  = at;
						o.refilled  = 1'b1;
					end
					blk_live[e] = 1'b1;
				end
			end
			idbrc_pkg::OP_FORGET_SPACE: begin
				for (int k = 0; k < NAME_COUNT; k++)
					blk_live[{r.space_index, 4'(k)}] = 1'b0;
			end
			idbrc_pkg::OP_FORGET_ALL: begin
				for (int k = 0; k < ENTRY_COUNT; k++)
					blk_live[k] = 1'b0;
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	function automatic logic [idbrc_pkg::COUNT_W-1:0] pick_count();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 3)
			return '0;
		else if (k < 50)
			return idbrc_pkg::COUNT_W'($urandom_range(1, 8));
		else if (k < 80)
			return idbrc_pkg::COUNT_W'($urandom_range(1, 300));
		else if (k < 95)
			return idbrc_pkg::COUNT_W'($urandom_range(1, 9000));
		return idbrc_pkg::COUNT_W'($urandom());
	endfunction

	// mostly reserves on a few hot names, with forgets and unused opcodes mixed in
	function automatic idbrc_pkg::req_t random_request();
		idbrc_pkg::req_t r;
		int unsigned     k;
		k                = $urandom_range(0, 99);
		r.space_index    = 2'($urandom_range(0, 3));
		r.seq_name_index = ($urandom_range(0, 9) < 6) ? 4'($urandom_range(0, 3))
			: 4'($urandom_range(0, 15));
		r.request_count  = pick_count();
		if (k < 89)
			r.opcode = idbrc_pkg::OP_RESERVE;
		else if (k < 95)
			r.opcode = idbrc_pkg::OP_FORGET_SPACE;
		else if (k < 97)
			r.opcode = idbrc_pkg::OP_FORGET_ALL;
		else
			r.opcode = OP_UNUSED;
		return r;
	endfunction

	task automatic queue_req(logic [1:0] op, logic [1:0] sp, logic [3:0] nm,
		logic [idbrc_pkg::COUNT_W-1:0] cnt);
		idbrc_pkg::req_t r;
		r.opcode         = op;
		r.space_index    = sp;
		r.seq_name_index = nm;
		r.request_count  = cnt;
		reqs_waiting     = {reqs_waiting, r};
	endtask

	// sampled at the falling edge so the driver's updates have settled
	task automatic wait_drained();
		while (reqs_waiting.size() != 0 || grants_due.size() != 0 || req_valid)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [idbrc_pkg::CFG_INDEX_W-1:0] idx,
		logic [idbrc_pkg::STEP_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == idbrc_pkg::CFG_INITIAL_STEP)
			cur_initial_step = val;
		else
			cur_step_cap = val;
		cfg_valid <= 1'b0;
	endtask

	// request driver
	always @(posedge clk) begin
		logic send;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				grants_due = {grants_due, apply_request(req)};
				if (req.opcode == idbrc_pkg::OP_FORGET_SPACE
					|| req.opcode == idbrc_pkg::OP_FORGET_ALL)
					forgets_seen++;
			end
			if (!(req_valid && req_stall)) begin
				send = (reqs_waiting.size() != 0)
					&& ($urandom_range(0, 99) >= send_idle_pct);
				if (send)
					req <= reqs_waiting.pop_front();
				req_valid <= send;
			end
		end
	end

	// response monitor
	always @(posedge clk) begin
		idbrc_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (grants_due.size() == 0) begin
					note_error($sformatf("response beat with nothing expected: %0d %0h %0d",
						rsp.status, rsp.first_id, rsp.refilled));
				end else begin
					want = grants_due.pop_front();
					beats_checked++;
					if (want.refilled)
						refills_seen++;
					if (want.status == idbrc_pkg::STATUS_REJECT)
						rejects_seen++;
					if (rsp.status !== want.status || rsp.first_id !== want.first_id
						|| rsp.refilled !== want.refilled)
						note_error($sformatf({"beat %0d: expected status %0d first_id %0h ",
							"refilled %0d, got status %0d first_id %0h refilled %0d"},
							beats_checked, want.status, want.first_id, want.refilled,
							rsp.status, rsp.first_id, rsp.refilled));
				end
			end
			rsp_stall <= ($urandom_range(0, 99) < sink_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			write_reg(idbrc_pkg::CFG_INITIAL_STEP, step_plan[ph]);
			write_reg(idbrc_pkg::CFG_STEP_CAP, cap_plan[ph]);
			case (ph * 3 / PHASES)
				0: begin
					send_idle_pct  = 25;
					sink_stall_pct = 63;
				end
				1: begin
					send_idle_pct  = 63;
					sink_stall_pct = 25;
				end
				default: begin
					send_idle_pct  = 0;
					sink_stall_pct = 0;
				end
			endcase
			if (ph == 0) begin
				// first refill, cache hit, exact fit, then empty block
				queue_req(idbrc_pkg::OP_RESERVE, 2'd0, 4'd0, 32'd1);
				queue_req(idbrc_pkg::OP_RESERVE, 2'd0, 4'd0, 32'd1);
				queue_req(idbrc_pkg::OP_RESERVE, 2'd0, 4'd0, 32'd62);
				queue_req(idbrc_pkg::OP_RESERVE, 2'd0, 4'd0, 32'd1);
				// zero count rejected
				queue_req(idbrc_pkg::OP_RESERVE, 2'd0, 4'd0, 32'd0);
				// largest count on the last entry
				queue_req(idbrc_pkg::OP_RESERVE, 2'd3, 4'd15, 32'hFFFF_FFFF);
				queue_req(idbrc_pkg::OP_RESERVE, 2'd3, 4'd15, 32'hFFFF_FFFF);
				queue_req(idbrc_pkg::OP_RESERVE, 2'd3, 4'd15, 32'd5);
				// counter survives a forget of its space
				queue_req(idbrc_pkg::OP_FORGET_SPACE, 2'd3, 4'd15, 32'hFFFF_FFFF);
				queue_req(idbrc_pkg::OP_RESERVE, 2'd3, 4'd15, 32'd5);
				queue_req(idbrc_pkg::OP_RESERVE, 2'd0, 4'd0, 32'd1);
				queue_req(OP_UNUSED, 2'd3, 4'd15, 32'hFFFF_FFFF);
				queue_req(idbrc_pkg::OP_FORGET_ALL, 2'd2, 4'd9, 32'd77);
				queue_req(idbrc_pkg::OP_RESERVE, 2'd0, 4'd0, 32'd1);
				queue_req(idbrc_pkg::OP_RESERVE, 2'd2, 4'd10, 32'd64);
				queue_req(idbrc_pkg::OP_RESERVE, 2'd2, 4'd10, 32'd65);
				queue_req(idbrc_pkg::OP_RESERVE, 2'd1, 4'd5, 32'd4096);
				// forgetting one space leaves the others cached
				queue_req(idbrc_pkg::OP_FORGET_SPACE, 2'd0, 4'd0, 32'd0);
				queue_req(idbrc_pkg::OP_RESERVE, 2'd1, 4'd5, 32'd1);
				queue_req(idbrc_pkg::OP_RESERVE, 2'd0, 4'd0, 32'hFFFF_FFFF);
				queue_req(idbrc_pkg::OP_RESERVE, 2'd2, 4'd10, 32'hAAAA_5555);
			end
			repeat (RANDOM_PER_PHASE)
				reqs_waiting = {reqs_waiting, random_request()};
		end
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (grants_due.size() != 0)
			note_error($sformatf("%0d response beats never arrived", grants_due.size()));
		$display("checked %0d response beats over %0d register settings in %0d cycles",
			beats_checked, PHASES, cycle_count);
		$display("  %0d refills, %0d rejects, %0d forget requests, %0d mismatches",
			refills_seen, rejects_seen, forgets_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
